[rtl/ist_pkg.sv]
// Shared types and codes for the interval set table.
`timescale 1ns / 1ps

package ist_pkg;

  // Command codes carried on the cmd field.
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_FILL   = 2'd3
  } ist_cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY,
    ST_WRITE2,
    ST_RESP
  } ist_state_t;

  // What the table scan found for the current position.
  typedef struct packed {
    logic holder;  // an interval covers the position
    logic left;    // an interval ends just below the position
    logic right;   // an interval starts just above the position
    logic free;    // at least one entry is unused
  } ist_hits_t;

endpackage

[rtl/ist_mem.sv]
// Interval storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module ist_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/ist_scan.sv]
// Scan unit: checks each entry read back from storage against the position.
`timescale 1ns / 1ps

module ist_scan #(
  parameter int MAX_RANGES    = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          issue,
  input  logic [$clog2(MAX_RANGES)-1:0] issue_idx,
  input  logic [MAX_RANGES-1:0]         entry_valid,
  input  logic [POSITION_BITS-1:0]      pos,
  input  logic [POSITION_BITS-1:0]      rd_first,
  input  logic [POSITION_BITS:0]        rd_len,
  output ist_pkg::ist_hits_t            hits,
  output logic [$clog2(MAX_RANGES)-1:0] holder_idx,
  output logic [POSITION_BITS-1:0]      holder_first,
  output logic [POSITION_BITS:0]        holder_len,
  output logic [$clog2(MAX_RANGES)-1:0] left_idx,
  output logic [POSITION_BITS-1:0]      left_first,
  output logic [POSITION_BITS:0]        left_len,
  output logic [$clog2(MAX_RANGES)-1:0] right_idx,
  output logic [POSITION_BITS:0]        right_len,
  output logic [$clog2(MAX_RANGES)-1:0] free_idx
);
  import ist_pkg::*;

  localparam int IW = $clog2(MAX_RANGES);
  localparam int LW = POSITION_BITS + 1;

  logic          chk_live;
  logic [IW-1:0] chk_idx;
  logic          chk_valid;
  logic [LW-1:0] first_ext;
  logic [LW-1:0] end_ext;
  logic [LW-1:0] pos_ext;
  logic          is_holder;
  logic          is_left;
  logic          is_right;

  // Read data arrives in the cycle after its address.
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_live <= 1'b0;
    end else begin
      chk_live <= issue;
    end
    chk_idx <= issue_idx;
  end

  always_comb begin
    chk_valid = entry_valid[chk_idx];
    first_ext = LW'(rd_first);
    end_ext   = first_ext + rd_len;
    pos_ext   = LW'(pos);
    is_holder = chk_valid && (pos_ext >= first_ext) && (pos_ext < end_ext);
    is_left   = chk_valid && (end_ext == pos_ext);
    is_right  = chk_valid && (first_ext == pos_ext + LW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      hits <= '0;
    end else if (chk_live) begin
      // holder and free keep the lowest match, neighbors the highest
      if (is_holder && !hits.holder) begin
        hits.holder  <= 1'b1;
        holder_idx   <= chk_idx;
        holder_first <= rd_first;
        holder_len   <= rd_len;
      end
      if (is_left) begin
        hits.left  <= 1'b1;
        left_idx   <= chk_idx;
        left_first <= rd_first;
        left_len   <= rd_len;
      end
      if (is_right) begin
        hits.right <= 1'b1;
        right_idx  <= chk_idx;
        right_len  <= rd_len;
      end
      if (!chk_valid && !hits.free) begin
        hits.free <= 1'b1;
        free_idx  <= chk_idx;
      end
    end
  end

endmodule

[rtl/interval_set_table_top.sv]
// Top level of the interval set table: sequencer, entry bookkeeping, result register.
`timescale 1ns / 1ps

// Holds a set of positions as up to MAX_RANGES disjoint, non-adjacent
// intervals (first, length) in a synchronous memory with one read and one
// write port; each entry has a valid flop that reset clears, so no clearing
// pass is needed after reset and the block is ready right away. Every add,
// remove or query reads all MAX_RANGES entries through the one read port,
// one per cycle, waits in the drain state for the last read data, then does
// the write-back in the apply state and answers in the response state; the
// input stalls until the block is idle again. A remove that splits an
// interval needs a second memory write in a state of its own. A fill skips
// the scan. A finished result sits in the output register while the next
// command is taken, so a stalled consumer only blocks once a second result
// is ready. Each beat in gives exactly one beat out; is_member is only set
// for a query, table_full_error flags an add or split that found no free
// entry (the table is left as it was), and range_total is the interval
// count after the command, low five bits.
module interval_set_table_top #(
  parameter int MAX_RANGES    = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] position,
  input  logic [16:0] fill_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_member,
  output logic        table_full_error,
  output logic [4:0]  range_total
);
  import ist_pkg::*;

  localparam int IW   = $clog2(MAX_RANGES);
  localparam int CNTW = $clog2(MAX_RANGES + 1);
  localparam int PB   = POSITION_BITS;
  localparam int LW   = PB + 1;
  localparam int DW   = PB + LW;
  localparam int CW   = (LW > 17) ? LW : 17;
  localparam logic [LW-1:0] SPAN = LW'(1) << PB;

  ist_state_t      state, state_next;

  // command beat held for the whole operation
  ist_cmd_t        op_cmd;
  logic [PB-1:0]   op_pos;
  logic [16:0]     op_flen;

  logic [MAX_RANGES-1:0] entry_valid;
  logic [CNTW-1:0] used_entries, used_next;
  logic [IW-1:0]   scan_cnt;

  logic            res_member, member_next;
  logic            res_err, err_next;

  logic            accept;
  logic            out_free;

  // memory port
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [DW-1:0]   wr_data;
  logic [DW-1:0]   rd_data;

  // valid-bit updates
  logic            set_en;
  logic [IW-1:0]   set_idx;
  logic            clr_en;
  logic [IW-1:0]   clr_idx;
  logic            clr_all;

  // scan findings
  ist_hits_t       hits;
  logic [IW-1:0]   holder_idx;
  logic [PB-1:0]   holder_first;
  logic [LW-1:0]   holder_len;
  logic [IW-1:0]   left_idx;
  logic [PB-1:0]   left_first;
  logic [LW-1:0]   left_len;
  logic [IW-1:0]   right_idx;
  logic [LW-1:0]   right_len;
  logic [IW-1:0]   free_idx;

  // derived values for remove and fill
  logic [LW-1:0]   hold_last;
  logic [LW-1:0]   pos_ext;
  logic            split_ok;
  logic [LW-1:0]   fill_room;
  logic [CW-1:0]   fill_want;
  logic [CW-1:0]   fill_cap;
  logic [LW-1:0]   fill_len;

  assign accept   = (state == ST_IDLE) && in_valid;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  ist_mem #(
    .DEPTH (MAX_RANGES),
    .WIDTH (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (scan_cnt),
    .rd_data (rd_data)
  );

  ist_scan #(
    .MAX_RANGES    (MAX_RANGES),
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .issue        (state == ST_SCAN),
    .issue_idx    (scan_cnt),
    .entry_valid  (entry_valid),
    .pos          (op_pos),
    .rd_first     (rd_data[DW-1:LW]),
    .rd_len       (rd_data[LW-1:0]),
    .hits         (hits),
    .holder_idx   (holder_idx),
    .holder_first (holder_first),
    .holder_len   (holder_len),
    .left_idx     (left_idx),
    .left_first   (left_first),
    .left_len     (left_len),
    .right_idx    (right_idx),
    .right_len    (right_len),
    .free_idx     (free_idx)
  );

  always_comb begin
    pos_ext   = LW'(op_pos);
    hold_last = LW'(holder_first) + holder_len - LW'(1);
    split_ok  = hits.free;
    // fill is clipped so the interval stops at the top position
    fill_room = SPAN - LW'(op_pos);
    fill_want = CW'(op_flen);
    fill_cap  = (fill_want > CW'(fill_room)) ? CW'(fill_room) : fill_want;
    fill_len  = LW'(fill_cap);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (ist_cmd_t'(cmd) == CMD_FILL) ? ST_APPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == IW'(MAX_RANGES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (op_cmd == CMD_REMOVE && hits.holder && holder_len > LW'(1) &&
            pos_ext != LW'(holder_first) && pos_ext != hold_last && split_ok) begin
          state_next = ST_WRITE2;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_WRITE2: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // write-back decisions
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    set_en      = 1'b0;
    set_idx     = '0;
    clr_en      = 1'b0;
    clr_idx     = '0;
    clr_all     = 1'b0;
    used_next   = used_entries;
    member_next = res_member;
    err_next    = res_err;
    unique case (state)
      ST_APPLY: begin
        member_next = 1'b0;
        err_next    = 1'b0;
        unique case (op_cmd)
          CMD_ADD: begin
            if (!hits.holder) begin
              priority if (hits.left && hits.right) begin
                // position bridges two intervals: fold right into left
                wr_en     = 1'b1;
                wr_addr   = left_idx;
                wr_data   = {left_first, left_len + LW'(1) + right_len};
                clr_en    = 1'b1;
                clr_idx   = right_idx;
                used_next = used_entries - CNTW'(1);
              end else if (hits.left) begin
                wr_en   = 1'b1;
                wr_addr = left_idx;
                wr_data = {left_first, left_len + LW'(1)};
              end else if (hits.right) begin
                wr_en   = 1'b1;
                wr_addr = right_idx;
                wr_data = {op_pos, right_len + LW'(1)};
              end else if (hits.free) begin
                wr_en     = 1'b1;
                wr_addr   = free_idx;
                wr_data   = {op_pos, LW'(1)};
                set_en    = 1'b1;
                set_idx   = free_idx;
                used_next = used_entries + CNTW'(1);
              end else begin
                err_next = 1'b1;
              end
            end
          end
          CMD_REMOVE: begin
            if (hits.holder) begin
              priority if (holder_len <= LW'(1)) begin
                clr_en    = 1'b1;
                clr_idx   = holder_idx;
                used_next = used_entries - CNTW'(1);
              end else if (pos_ext == LW'(holder_first)) begin
                wr_en   = 1'b1;
                wr_addr = holder_idx;
                wr_data = {op_pos + PB'(1), holder_len - LW'(1)};
              end else if (pos_ext == hold_last) begin
                wr_en   = 1'b1;
                wr_addr = holder_idx;
                wr_data = {holder_first, holder_len - LW'(1)};
              end else if (split_ok) begin
                // lower half stays here, upper half goes out next cycle
                wr_en   = 1'b1;
                wr_addr = holder_idx;
                wr_data = {holder_first, LW'(op_pos - holder_first)};
              end else begin
                err_next = 1'b1;
              end
            end
          end
          CMD_QUERY: begin
            member_next = hits.holder;
          end
          CMD_FILL: begin
            clr_all = 1'b1;
            if (fill_len != '0) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_data   = {op_pos, fill_len};
              set_en    = 1'b1;
              set_idx   = '0;
              used_next = CNTW'(1);
            end else begin
              used_next = '0;
            end
          end
          default: begin
          end
        endcase
      end
      ST_WRITE2: begin
        wr_en     = 1'b1;
        wr_addr   = free_idx;
        wr_data   = {op_pos + PB'(1), hold_last - pos_ext};
        set_en    = 1'b1;
        set_idx   = free_idx;
        used_next = used_entries + CNTW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_valid  <= '0;
      used_entries <= '0;
      scan_cnt     <= '0;
      res_member   <= 1'b0;
      res_err      <= 1'b0;
    end else begin
      state        <= state_next;
      used_entries <= used_next;
      res_member   <= member_next;
      res_err      <= err_next;
      if (accept) begin
        scan_cnt <= '0;
      end else if (state == ST_SCAN && scan_cnt != IW'(MAX_RANGES - 1)) begin
        scan_cnt <= scan_cnt + IW'(1);
      end
      // fill clears every entry and marks only the one it loads
      if (clr_all) begin
        entry_valid <= set_en ? (MAX_RANGES'(1) << set_idx) : '0;
      end else if (clr_en) begin
        entry_valid[clr_idx] <= 1'b0;
      end else if (set_en) begin
        entry_valid[set_idx] <= 1'b1;
      end
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd  <= ist_cmd_t'(cmd);
      op_pos  <= PB'(position);
      op_flen <= fill_length;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      is_member        <= res_member;
      table_full_error <= res_err;
      range_total      <= 5'(used_entries);
    end
  end

  // entry count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(used_entries))
    else $error("entry count out of step with valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(used_entries) <= MAX_RANGES)
    else $error("entry count above table size");

  // storage must not change under the scan
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_DRAIN) |-> !wr_en)
    else $error("memory write during scan");

  // a new result comes only out of the response state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESP)
    else $error("result loaded outside response state");

endmodule

[tb/interval_set_table_top_tb.sv]
// Self-checking testbench for the interval set table: directed rows, then random commands.
`timescale 1ns / 1ps

module interval_set_table_top_tb;
  import ist_pkg::*;

  localparam int MAX_RANGES  = 16;
  localparam int POS_SPAN    = 65536;   // one past the largest position
  localparam int RANDOM_BEATS = 925;    // stop offering once this many beats went in
  localparam int HOLDOFF_AT  = 150;     // beats in before the long receiver hold-off
  localparam int HOLDOFF_CYCLES = 500;
  localparam int DRAIN_CYCLES = 40;     // extra wait after the last result is checked
  localparam int CYCLE_LIMIT = 300000;

  // One result beat as the block reports it.
  typedef struct packed {
    logic       member;
    logic       full_err;
    logic [4:0] total;
  } outcome_t;

  // Directed stimulus row; typed rows carry their result, the rest use the predictor.
  typedef struct packed {
    ist_cmd_t    op;
    logic [15:0] pos;
    logic [16:0] flen;
    logic        typed;
    outcome_t    want;
  } directed_row_t;

  // Traffic shaping phases, stepped every hundred input beats.
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [15:0] position;
  logic [16:0] fill_length;
  logic        out_valid;
  logic        out_stall;
  logic        is_member;
  logic        table_full_error;
  logic [4:0]  range_total;

  // Predicted table contents.
  int unsigned iv_first [MAX_RANGES];
  int unsigned iv_len   [MAX_RANGES];
  bit          iv_used  [MAX_RANGES];
  int unsigned iv_count;

  outcome_t pending_outcomes[$];
  int       beats_in;
  int       errors;
  int       cycle_count;
  bit       holdoff_done;

  // Directed rows: reset state, both position edges, every way add and
  // remove can touch a neighbor, and the fill corner cases.
  directed_row_t directed_rows[25] = '{
    '{CMD_QUERY,  16'd0,     17'd0,     1'b1, '{1'b0, 1'b0, 5'd0}},  // empty after reset
    '{CMD_REMOVE, 16'd5,     17'd0,     1'b1, '{1'b0, 1'b0, 5'd0}},  // absent position
    '{CMD_ADD,    16'd0,     17'd0,     1'b1, '{1'b0, 1'b0, 5'd1}},  // bottom edge
    '{CMD_ADD,    16'd65535, 17'd0,     1'b1, '{1'b0, 1'b0, 5'd2}},  // top edge, no wrap
    '{CMD_QUERY,  16'd65535, 17'd0,     1'b1, '{1'b1, 1'b0, 5'd2}},
    '{CMD_ADD,    16'd1,     17'd0,     1'b0, '0},                   // grow at the end
    '{CMD_ADD,    16'd3,     17'd65536, 1'b0, '0},                   // fill_length ignored
    '{CMD_ADD,    16'd2,     17'd0,     1'b0, '0},                   // closes the gap, merge
    '{CMD_ADD,    16'd2,     17'd0,     1'b0, '0},                   // already covered
    '{CMD_ADD,    16'd65534, 17'd0,     1'b0, '0},                   // grow at the start
    '{CMD_REMOVE, 16'd0,     17'd0,     1'b0, '0},                   // trim the first position
    '{CMD_REMOVE, 16'd3,     17'd0,     1'b0, '0},                   // trim the last position
    '{CMD_ADD,    16'd5,     17'd0,     1'b0, '0},
    '{CMD_REMOVE, 16'd5,     17'd0,     1'b0, '0},                   // entry becomes empty
    '{CMD_ADD,    16'd3,     17'd0,     1'b0, '0},
    '{CMD_ADD,    16'd4,     17'd0,     1'b0, '0},
    '{CMD_REMOVE, 16'd2,     17'd0,     1'b0, '0},                   // interior point, split
    '{CMD_QUERY,  16'd2,     17'd0,     1'b0, '0},
    '{CMD_FILL,   16'd65530, 17'd65536, 1'b1, '{1'b0, 1'b0, 5'd1}},  // clipped at the top
    '{CMD_QUERY,  16'd65535, 17'd0,     1'b1, '{1'b1, 1'b0, 5'd1}},
    '{CMD_QUERY,  16'd65529, 17'd0,     1'b1, '{1'b0, 1'b0, 5'd1}},
    '{CMD_FILL,   16'd0,     17'd0,     1'b1, '{1'b0, 1'b0, 5'd0}},  // zero length, empty set
    '{CMD_FILL,   16'd0,     17'd65536, 1'b1, '{1'b0, 1'b0, 5'd1}},  // whole position span
    '{CMD_REMOVE, 16'd32768, 17'd0,     1'b0, '0},
    '{CMD_FILL,   16'd65535, 17'd1,     1'b1, '{1'b0, 1'b0, 5'd1}}
  };

  interval_set_table_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .position         (position),
    .fill_length      (fill_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .is_member        (is_member),
    .table_full_error (table_full_error),
    .range_total      (range_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic idle_mode_t current_idle_mode();
    return idle_mode_t'((beats_in / 100) % 4);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic int covering_entry(input int unsigned p);
    for (int k = 0; k < MAX_RANGES; k++)
      if (iv_used[k] && p >= iv_first[k] && p < iv_first[k] + iv_len[k])
        return k;
    return -1;
  endfunction

  function automatic int lowest_free_entry();
    for (int k = 0; k < MAX_RANGES; k++)
      if (!iv_used[k])
        return k;
    return -1;
  endfunction

  function automatic void claim_entry(input int k, input int unsigned first,
                                      input int unsigned len);
    iv_used[k]  = 1'b1;
    iv_first[k] = first;
    iv_len[k]   = len;
    iv_count++;
  endfunction

  function automatic void release_entry(input int k);
    iv_used[k] = 1'b0;
    if (iv_count > 0)
      iv_count--;
  endfunction

  function automatic void clear_intervals();
    for (int k = 0; k < MAX_RANGES; k++)
      iv_used[k] = 1'b0;
    iv_count = 0;
  endfunction

  // Applies one command to the predicted table and returns its result beat.
  function automatic outcome_t predict_interval_cmd(input ist_cmd_t op,
                                                    input logic [15:0] pos,
                                                    input logic [16:0] flen);
    outcome_t    res;
    int unsigned p;
    int unsigned first;
    int unsigned last;
    int unsigned span;
    int          k;
    int          lo;
    int          hi;
    res = '0;
    p   = pos;
    case (op)
      CMD_ADD: begin
        if (covering_entry(p) < 0) begin
          lo = -1;
          hi = -1;
          for (int j = 0; j < MAX_RANGES; j++) begin
            if (iv_used[j] && iv_first[j] + iv_len[j] == p) lo = j;
            if (iv_used[j] && iv_first[j] == p + 1) hi = j;
          end
          if (lo >= 0 && hi >= 0) begin
            iv_len[lo] += 1 + iv_len[hi];
            release_entry(hi);
          end else if (lo >= 0) begin
            iv_len[lo] += 1;
          end else if (hi >= 0) begin
            iv_first[hi] -= 1;
            iv_len[hi]   += 1;
          end else begin
            k = lowest_free_entry();
            if (k < 0) res.full_err = 1'b1;
            else claim_entry(k, p, 1);
          end
        end
      end
      CMD_REMOVE: begin
        k = covering_entry(p);
        if (k >= 0) begin
          first = iv_first[k];
          last  = first + iv_len[k] - 1;
          if (iv_len[k] <= 1) begin
            release_entry(k);
          end else if (p == first) begin
            iv_first[k] = first + 1;
            iv_len[k]  -= 1;
          end else if (p == last) begin
            iv_len[k] -= 1;
          end else begin
            lo = lowest_free_entry();
            if (lo < 0) begin
              res.full_err = 1'b1;
            end else begin
              iv_len[k] = p - first;
              claim_entry(lo, p + 1, last - p);
            end
          end
        end
      end
      CMD_QUERY: begin
        res.member = covering_entry(p) >= 0;
      end
      default: begin
        clear_intervals();
        span = POS_SPAN - p;
        if (flen < span) span = flen;
        if (span > 0) claim_entry(0, p, span);
      end
    endcase
    res.total = iv_count[4:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- sender

  // Offers one beat at a falling edge, holds it until accepted, then records
  // what the block should answer.
  task automatic issue_beat(input ist_cmd_t op, input logic [15:0] pos,
                            input logic [16:0] flen, input bit use_typed,
                            input outcome_t typed_out);
    outcome_t predicted;
    int       idle_pct;
    @(negedge clk);
    idle_pct = (current_idle_mode() == IDLE_SENDER) ? 46 :
               (current_idle_mode() == IDLE_BOTH)   ? 6  : 0;
    while (roll(idle_pct)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    cmd         = op;
    position    = pos;
    fill_length = flen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_interval_cmd(op, pos, flen);
    pending_outcomes.push_back(use_typed ? typed_out : predicted);
    beats_in++;
  endtask

  // ---------------------------------------------------------------- receiver

  // Random stall by phase, plus one long hold-off so the block backs up
  // into its input while the sender keeps offering.
  initial begin : receiver
    int stall_pct;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!holdoff_done && beats_in >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        out_stall    = 1'b1;
        repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
      end else begin
        stall_pct = (current_idle_mode() == IDLE_RECEIVER) ? 46 :
                    (current_idle_mode() == IDLE_BOTH)     ? 6  : 0;
        out_stall = roll(stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result beat with nothing pending: member=%0b err=%0b total=%0d",
                 $time, is_member, table_full_error, range_total);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (is_member !== want.member) begin
          $display("%0t: is_member expected %0b actual %0b", $time, want.member, is_member);
          errors++;
        end
        if (table_full_error !== want.full_err) begin
          $display("%0t: table_full_error expected %0b actual %0b",
                   $time, want.full_err, table_full_error);
          errors++;
        end
        if (range_total !== want.total) begin
          $display("%0t: range_total expected %0d actual %0d",
                   $time, want.total, range_total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count++;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("interval_set_table_top_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    ist_cmd_t    op;
    logic [15:0] pos;
    logic [16:0] flen;
    int          base;
    int          width;
    int          kind;
    int          steps;
    int          r;
    bit          noise;

    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = CMD_ADD;
    position     = '0;
    fill_length  = '0;
    beats_in     = 0;
    errors       = 0;
    cycle_count  = 0;
    holdoff_done = 1'b0;
    clear_intervals();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      issue_beat(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].flen,
                 directed_rows[i].typed, directed_rows[i].want);

    // Full table: one three-wide interval plus fifteen isolated points,
    // then an add that needs an entry and a split of the wide interval.
    base = $urandom_range(0, 65535 - 48);
    issue_beat(CMD_FILL, base[15:0], 17'd3, 1'b0, '0);
    for (int i = 0; i < MAX_RANGES - 1; i++)
      issue_beat(CMD_ADD, base[15:0] + 16'(4 + 2 * i), 17'd0, 1'b0, '0);
    issue_beat(CMD_ADD, base[15:0] + 16'd40, 17'd0, 1'b0, '0);
    issue_beat(CMD_REMOVE, base[15:0] + 16'd1, 17'd0, 1'b0, '0);
    issue_beat(CMD_QUERY, base[15:0] + 16'd1, 17'd0, 1'b0, '0);

    // Random episodes, mostly clustered in a narrow window so adds and
    // removes keep hitting neighbors, merges, splits and a full table.
    while (beats_in < RANDOM_BEATS) begin
      kind  = $urandom_range(0, 99);
      width = $urandom_range(4, 48);
      noise = 1'b0;
      if (kind < 70) base = $urandom_range(0, 65535 - width);
      else if (kind < 80) base = 0;
      else if (kind < 90) base = 65535 - width;
      else noise = 1'b1;
      if (!noise && roll(50))
        issue_beat(CMD_FILL, base[15:0], 17'($urandom_range(0, width)), 1'b0, '0);
      steps = $urandom_range(10, 60);
      for (int s = 0; s < steps && beats_in < RANDOM_BEATS; s++) begin
        r = $urandom_range(0, 99);
        if (r < 45) op = CMD_ADD;
        else if (r < 70) op = CMD_REMOVE;
        else if (r < 92) op = CMD_QUERY;
        else op = CMD_FILL;
        pos = noise ? 16'($urandom_range(0, 65535)) : 16'(base + $urandom_range(0, width));
        r = $urandom_range(0, 99);
        if (r < 10) flen = 17'd0;
        else if (r < 20) flen = 17'd65536;
        else if (r < 40) flen = 17'($urandom_range(0, 65536));
        else flen = 17'($urandom_range(1, width));
        issue_beat(op, pos, flen, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("interval_set_table_top_tb passed");
    else
      $display("interval_set_table_top_tb failed");
    $finish;
  end

endmodule
